### rtl/sws_pkg.sv
// types and constants for the sliding window sender control block
// no dependencies; imported by the core and by its checker

package sws_pkg;

    localparam int RESULT_CAP  = 64;
    localparam int CNT_W       = 7;
    localparam int DUP_TRIGGER = 3;
    localparam int DUP_SAT     = 4;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_ACK   = 1'b1;

    localparam logic KIND_SEND = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic CFG_WINDOW_SIZE   = 1'b0;
    localparam logic CFG_TOTAL_PACKETS = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [31:0] ack_seq;
        logic [31:0] conn_id;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] pkt_seq;
        logic [31:0] conn_out;
        logic        fast_retx;
        logic        last;
    } out_item_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_UPDATE = 5'b00010,
        ST_CHECK  = 5'b00100,
        ST_SHOW   = 5'b01000,
        ST_DRAIN  = 5'b10000
    } state_t;

endpackage

### rtl/sliding_window_sender_control_core.sv
// sliding window sender control core: go-back-n window with fast retransmit
// depends on sws_pkg
//
// usage:
//   s_ channel takes one item: a start command or an acknowledgement.
//   m_ channel returns the items it causes: send requests and a done item,
//   the last one of each run marked by last.
//   cfg_we/cfg_addr/cfg_wdata write the window limit (0) and total_packets (1);
//   write only while idle.
// timing:
//   an item is latched on acceptance and updates the window state in
//   ST_UPDATE; each result then passes the single window compare unit
//   in ST_CHECK and holds while the receiver keeps m_ready low. s_ready
//   is low from acceptance until the last result is taken.
//   an ack with no result returns to idle from ST_CHECK, or from ST_UPDATE once finished.
// reset:
//   aresetn low clears the window state; the window limit returns to 4 and
//   total_packets to 1. no output is pending after reset.
// stalls:
//   a shown result holds until m_ready; the sequencer waits meanwhile.

module sliding_window_sender_control_core
    import sws_pkg::*;
#(
    parameter int MAX_WINDOW = 64,
    parameter int SEQ_WIDTH  = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data,
    input  logic      cfg_we,
    input  logic      cfg_addr,
    input  logic [31:0] cfg_wdata
);

    localparam int TW = (SEQ_WIDTH > 32) ? SEQ_WIDTH : 32;

    state_t                 state_reg, state_next;
    logic                   m_valid_reg, m_valid_next;
    out_item_t              out_reg, out_next;
    logic [6:0]             win_limit_reg;
    logic [31:0]            total_reg;
    logic [SEQ_WIDTH-1:0]   next_seq_reg, next_seq_next;
    logic [SEQ_WIDTH-1:0]   last_acked_reg, last_acked_next;
    logic [2:0]             dup_reg, dup_next;
    logic                   finished_reg, finished_next;
    logic                   cmd_reg;
    logic [SEQ_WIDTH-1:0]   ack_reg;
    logic [31:0]            conn_reg;
    logic [6:0]             win_reg, win_next;
    logic                   fast_reg, fast_next;
    logic [CNT_W-1:0]       n_reg, n_next;

    logic [SEQ_WIDTH-1:0]   final_seq;
    logic [SEQ_WIDTH-1:0]   ack_plus1;
    logic [SEQ_WIDTH-1:0]   seq_diff;
    logic [2:0]             dup_inc;
    logic                   cond;
    out_item_t              cand;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign final_seq = SEQ_WIDTH'(TW'(total_reg) - TW'(1));
    assign ack_plus1 = ack_reg + SEQ_WIDTH'(1);
    assign dup_inc   = (dup_reg < 3'(DUP_SAT)) ? dup_reg + 3'd1 : dup_reg;

    // shared window compare unit
    assign seq_diff = next_seq_reg - ack_reg;
    assign cond = (n_reg < CNT_W'(RESULT_CAP))
               && (TW'(next_seq_reg) < TW'(total_reg))
               && ((next_seq_reg <= ack_reg) || (seq_diff <= SEQ_WIDTH'(win_reg)));

    always_comb begin
        cand.kind      = KIND_SEND;
        cand.pkt_seq   = 32'(next_seq_reg);
        cand.conn_out  = conn_reg;
        cand.fast_retx = fast_reg;
        cand.last      = 1'b0;
    end

    always_comb begin
        state_next      = state_reg;
        m_valid_next    = m_valid_reg;
        out_next        = out_reg;
        next_seq_next   = next_seq_reg;
        last_acked_next = last_acked_reg;
        dup_next        = dup_reg;
        finished_next   = finished_reg;
        win_next        = win_reg;
        fast_next       = fast_reg;
        n_next          = n_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_next    = '0;
                fast_next = 1'b0;
                if (cmd_reg == CMD_START) begin
                    next_seq_next   = SEQ_WIDTH'(1);
                    last_acked_next = '0;
                    dup_next        = '0;
                    finished_next   = 1'b0;
                    out_next        = '{KIND_SEND, 32'd0, 32'd0, 1'b0, 1'b1};
                    m_valid_next    = 1'b1;
                    state_next      = ST_DRAIN;
                end else if (finished_reg) begin
                    state_next = ST_IDLE;
                end else if (ack_reg == final_seq) begin
                    finished_next = 1'b1;
                    out_next      = '{KIND_DONE, 32'(ack_reg), conn_reg, 1'b0, 1'b1};
                    m_valid_next  = 1'b1;
                    state_next    = ST_DRAIN;
                end else begin
                    win_next = (win_limit_reg > 7'(MAX_WINDOW)) ? 7'(MAX_WINDOW)
                                                                : win_limit_reg;
                    if (ack_reg == last_acked_reg) begin
                        dup_next = dup_inc;
                        win_next = 7'd1;
                        if (dup_inc == 3'(DUP_TRIGGER)) begin
                            next_seq_next = ack_plus1;
                            fast_next     = 1'b1;
                        end
                    end else begin
                        if (next_seq_reg <= ack_reg) begin
                            next_seq_next = ack_plus1;
                        end
                        dup_next = '0;
                    end
                    last_acked_next = ack_reg;
                    state_next      = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (cond) begin
                    if (n_reg != '0) begin
                        m_valid_next = 1'b1;
                        state_next   = ST_SHOW;
                    end else begin
                        out_next      = cand;
                        next_seq_next = next_seq_reg + SEQ_WIDTH'(1);
                        n_next        = n_reg + CNT_W'(1);
                    end
                end else if (n_reg != '0) begin
                    out_next.last = 1'b1;
                    m_valid_next  = 1'b1;
                    state_next    = ST_DRAIN;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SHOW: begin
                if (m_ready) begin
                    m_valid_next  = 1'b0;
                    out_next      = cand;
                    next_seq_next = next_seq_reg + SEQ_WIDTH'(1);
                    n_next        = n_reg + CNT_W'(1);
                    state_next    = ST_CHECK;
                end
            end
            ST_DRAIN: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next   = ST_IDLE;
                m_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            win_limit_reg   <= 7'd4;
            total_reg       <= 32'd1;
            next_seq_reg    <= '0;
            last_acked_reg  <= '0;
            dup_reg         <= '0;
            finished_reg    <= 1'b0;
            n_reg           <= '0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            next_seq_reg   <= next_seq_next;
            last_acked_reg <= last_acked_next;
            dup_reg        <= dup_next;
            finished_reg   <= finished_next;
            n_reg          <= n_next;
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_WINDOW_SIZE:   win_limit_reg <= cfg_wdata[6:0];
                    CFG_TOTAL_PACKETS: total_reg     <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        win_reg  <= win_next;
        fast_reg <= fast_next;
        if (s_valid && s_ready) begin
            cmd_reg  <= s_data.cmd;
            ack_reg  <= SEQ_WIDTH'(s_data.ack_seq);
            conn_reg <= s_data.conn_id;
        end
    end

endmodule

### rtl/sws_checker.sv
// port-level checks for the sliding window sender control core
// depends on sws_pkg; bound to sliding_window_sender_control_core below

module sws_checker
    import sws_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // a waiting result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // busy right after an item is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after accepting an item");

    // no new item while a result is pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("ready while a result is pending");

    // done item ends its run and never carries fast retransmit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.kind == KIND_DONE) |-> m_data.last && !m_data.fast_retx)
        else $error("malformed done item");

endmodule

bind sliding_window_sender_control_core sws_checker u_sws_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
